[hw/rtl/prime_count_in_range_defines.svh]
// Assertion macros for the prime counter.
`ifndef PRIME_COUNT_IN_RANGE_DEFINES_SVH
`define PRIME_COUNT_IN_RANGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PCR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("prime counter assertion failed");
`define PCR_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("prime counter forbidden condition");
`else
`define PCR_ASSERT(lbl, clk, rstn, prop)
`define PCR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[hw/rtl/pcr_pkg.sv]
package pcr_pkg;

    localparam int FIRST_PRIME = 2;
    localparam int COUNT_W     = 12;
    localparam int M_TDATA_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_CHECK,
        ST_DIV,
        ST_REM,
        ST_ADV,
        ST_DONE
    } pcr_state_t;

    typedef struct packed {
        logic load;
        logic init_div;
        logic start_rem;
        logic div_step;
        logic next_div;
        logic count_inc;
        logic next_cand;
        logic out_load;
    } pcr_cmd_t;

    typedef struct packed {
        logic empty;
        logic n_is_two;
        logic n_even;
        logic dsq_gt_n;
        logic div_last;
        logic rem_zero;
        logic n_is_hi;
        logic out_free;
    } pcr_status_t;

endpackage

[hw/rtl/pcr_ctrl.sv]
module pcr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pcr_pkg::pcr_status_t status,
    output pcr_pkg::pcr_cmd_t    cmd
);

    pcr_pkg::pcr_state_t state_reg;
    pcr_pkg::pcr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pcr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = pcr_pkg::ST_CAND;
                end
            end
            pcr_pkg::ST_CAND: begin
                if (status.empty) begin
                    state_next = pcr_pkg::ST_DONE;
                end else if (status.n_is_two) begin
                    cmd.count_inc = 1'b1;
                    state_next    = pcr_pkg::ST_ADV;
                end else if (status.n_even) begin
                    state_next = pcr_pkg::ST_ADV;
                end else begin
                    cmd.init_div = 1'b1;
                    state_next   = pcr_pkg::ST_CHECK;
                end
            end
            pcr_pkg::ST_CHECK: begin
                if (status.dsq_gt_n) begin
                    cmd.count_inc = 1'b1;
                    state_next    = pcr_pkg::ST_ADV;
                end else begin
                    cmd.start_rem = 1'b1;
                    state_next    = pcr_pkg::ST_DIV;
                end
            end
            pcr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = pcr_pkg::ST_REM;
                end
            end
            pcr_pkg::ST_REM: begin
                if (status.rem_zero) begin
                    state_next = pcr_pkg::ST_ADV;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = pcr_pkg::ST_CHECK;
                end
            end
            pcr_pkg::ST_ADV: begin
                if (status.n_is_hi) begin
                    state_next = pcr_pkg::ST_DONE;
                end else begin
                    cmd.next_cand = 1'b1;
                    state_next    = pcr_pkg::ST_CAND;
                end
            end
            pcr_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = pcr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pcr_dpath.sv]
`include "prime_count_in_range_defines.svh"

module pcr_dpath #(
    parameter int VALUE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcr_pkg::pcr_cmd_t             cmd,
    output pcr_pkg::pcr_status_t          status,
    input  logic [VALUE_BITS-1:0]         first_bound,
    input  logic [VALUE_BITS-1:0]         second_bound,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pcr_pkg::COUNT_W-1:0]   prime_count
);

    localparam int UW = VALUE_BITS - 1;
    localparam int SW = UW + 2;
    localparam int CW = $clog2(UW);
    localparam logic signed [VALUE_BITS-1:0] TWO_S = VALUE_BITS'(pcr_pkg::FIRST_PRIME);

    logic signed [VALUE_BITS-1:0] a_s;
    logic signed [VALUE_BITS-1:0] b_s;
    logic signed [VALUE_BITS-1:0] lo_s;
    logic signed [VALUE_BITS-1:0] hi_s;
    logic [UW-1:0]                lo_start;

    logic [UW-1:0]                n_reg;
    logic [UW-1:0]                hi_reg;
    logic                         empty_reg;
    logic [UW-1:0]                d_reg;
    logic [SW-1:0]                dsq_reg;
    logic [UW-1:0]                rem_reg;
    logic [UW-1:0]                rem_next;
    logic [UW-1:0]                quo_reg;
    logic [CW-1:0]                bit_reg;
    logic [pcr_pkg::COUNT_W-1:0]  count_reg;
    logic                         m_tvalid_reg;
    logic [pcr_pkg::COUNT_W-1:0]  m_data_reg;

    logic [UW:0]                  rem_sh;
    logic                         rem_ge;

    assign a_s      = signed'(first_bound);
    assign b_s      = signed'(second_bound);
    assign lo_s     = (a_s < b_s) ? a_s : b_s;
    assign hi_s     = (a_s < b_s) ? b_s : a_s;
    assign lo_start = (lo_s < TWO_S) ? UW'(pcr_pkg::FIRST_PRIME) : lo_s[UW-1:0];

    assign rem_sh   = {rem_reg, quo_reg[UW-1]};
    assign rem_ge   = rem_sh >= {1'b0, d_reg};
    assign rem_next = rem_ge ? UW'(rem_sh - {1'b0, d_reg}) : rem_sh[UW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg     <= lo_start;
            hi_reg    <= hi_s[UW-1:0];
            empty_reg <= hi_s < TWO_S;
            count_reg <= '0;
        end else begin
            if (cmd.next_cand) begin
                n_reg <= n_reg + UW'(1);
            end
            if (cmd.count_inc && count_reg != pcr_pkg::COUNT_MAX) begin
                count_reg <= count_reg + pcr_pkg::COUNT_W'(1);
            end
        end
        if (cmd.init_div) begin
            d_reg   <= UW'(3);
            dsq_reg <= SW'(9);
        end else if (cmd.next_div) begin
            d_reg   <= d_reg + UW'(2);
            dsq_reg <= dsq_reg + (SW'(d_reg) << 2) + SW'(4);
        end
        if (cmd.start_rem) begin
            rem_reg <= '0;
            quo_reg <= n_reg;
            bit_reg <= CW'(UW - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_reg << 1;
            bit_reg <= bit_reg - CW'(1);
        end
        if (cmd.out_load) begin
            m_data_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        status          = '0;
        status.empty    = empty_reg;
        status.n_is_two = n_reg == UW'(pcr_pkg::FIRST_PRIME);
        status.n_even   = !n_reg[0];
        status.dsq_gt_n = dsq_reg > SW'(n_reg);
        status.div_last = bit_reg == '0;
        status.rem_zero = rem_reg == '0;
        status.n_is_hi  = n_reg == hi_reg;
        status.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid    = m_tvalid_reg;
    assign prime_count = m_data_reg;

    `PCR_ASSERT_NEVER(a_div_even, aclk, aresetn, cmd.div_step && !d_reg[0])
    `PCR_ASSERT(a_rem_bound, aclk, aresetn, $past(cmd.div_step) |-> rem_reg < d_reg)
    `PCR_ASSERT(a_count_moves, aclk, aresetn, cmd.count_inc |=> count_reg != '0)
    `PCR_ASSERT_NEVER(a_load_busy, aclk, aresetn, cmd.out_load && m_tvalid_reg && !m_tready)

endmodule

[hw/rtl/prime_count_in_range.sv]
// Prime counter over a signed interval.
// Input channel (s_): one transfer carries two signed bounds of VALUE_BITS each,
// in either order; the block counts the primes p with lo <= p <= hi by trial
// division with odd divisors up to the square root of each candidate.
// Result channel (m_): one transfer per input item, a 12-bit count that
// saturates at 4095; intervals wholly below two give zero.
// Per candidate, 2 is counted at once and other even candidates are skipped;
// each odd candidate is divided by odd trial divisors from 3 until one divides
// it or the divisor's square exceeds it, using a bit-serial remainder unit of
// VALUE_BITS - 1 steps per divisor.
// One item is in work at a time; s_tready is high only while idle.
// The result waits in an output register, so a new item may be taken
// while the receiver stalls; a finished count holds until the register frees.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any pending result.
module prime_count_in_range #(
    parameter int VALUE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // first_bound, second_bound
    input  logic [((2*VALUE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // prime_count
    output logic [pcr_pkg::M_TDATA_W-1:0]          m_tdata
);

    pcr_pkg::pcr_cmd_t              cmd;
    pcr_pkg::pcr_status_t           status;
    logic [pcr_pkg::COUNT_W-1:0]    prime_count;

    pcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcr_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .first_bound  (s_tdata[VALUE_BITS-1:0]),
        .second_bound (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .prime_count  (prime_count)
    );

    assign m_tdata = {{(pcr_pkg::M_TDATA_W - pcr_pkg::COUNT_W){1'b0}}, prime_count};

endmodule

[verif/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS  = 16;
    localparam int S_TDATA_W   = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int RANDOM_SPANS = 76;
    localparam int CALM_TAIL   = 15;
    localparam int MAX_SHOWN   = 10;

    typedef logic signed [VALUE_BITS-1:0] bound_t;

    typedef struct {
        bound_t                      first_bound;
        bound_t                      second_bound;
        logic [pcr_pkg::COUNT_W-1:0] prime_count;
    } span_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [S_TDATA_W-1:0]          s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pcr_pkg::M_TDATA_W-1:0] m_tdata;

    span_t   spans_pending[$];
    span_t   counts_due[$];
    span_t   span_on_bus;
    span_t   next_span;
    span_t   due_span;
    int      send_gap   = 0;
    int      recv_stall = 0;
    int      errors     = 0;
    longint  cycles     = 0;
    longint  run_limit  = 0;
    longint  work_total = 0;

    prime_count_in_range #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // work is a rough cycle estimate of the trial-division controller
    function automatic logic [pcr_pkg::COUNT_W-1:0] count_primes_between(
        input  bound_t a,
        input  bound_t b,
        output longint work
    );
        longint      lo;
        longint      hi;
        longint      n;
        longint      d;
        bit          prime;
        int unsigned total;
        lo    = (a < b) ? a : b;
        hi    = (a < b) ? b : a;
        total = 0;
        work  = 3;
        if (lo < 2) begin
            lo = 2;
        end
        for (n = lo; n <= hi; n++) begin
            work += 2;
            if (n == 2) begin
                prime = 1'b1;
            end else if (n % 2 == 0) begin
                prime = 1'b0;
            end else begin
                work += 1;
                prime = 1'b1;
                for (d = 3; d * d <= n && prime; d += 2) begin
                    work += VALUE_BITS + 1;
                    if (n % d == 0) begin
                        prime = 1'b0;
                    end
                end
            end
            if (prime && total < (1 << pcr_pkg::COUNT_W) - 1) begin
                total++;
            end
        end
        return total[pcr_pkg::COUNT_W-1:0];
    endfunction

    task automatic add_span(input int a, input int b);
        span_t  span;
        longint work;
        span.first_bound  = bound_t'(a);
        span.second_bound = bound_t'(b);
        span.prime_count  = count_primes_between(span.first_bound, span.second_bound, work);
        work_total += work + 25;
        spans_pending.push_back(span);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                counts_due.push_back(span_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (spans_pending.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
                    send_gap <= $urandom_range(0, 9);
                    s_tvalid <= 1'b0;
                end else if (spans_pending.size() > 0) begin
                    next_span = spans_pending.pop_front();
                    s_tvalid    <= 1'b1;
                    s_tdata     <= {next_span.second_bound, next_span.first_bound};
                    span_on_bus <= next_span;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (counts_due.size() == 0) begin
                    if (errors < MAX_SHOWN) begin
                        $display("unexpected result transfer: prime_count %0d",
                                 m_tdata[pcr_pkg::COUNT_W-1:0]);
                    end
                    errors++;
                end else begin
                    due_span = counts_due.pop_front();
                    if (m_tdata[pcr_pkg::COUNT_W-1:0] !== due_span.prime_count) begin
                        if (errors < MAX_SHOWN) begin
                            $display({"prime_count mismatch for bounds %0d, %0d: ",
                                      "expected %0d, got %0d"},
                                     due_span.first_bound, due_span.second_bound,
                                     due_span.prime_count,
                                     m_tdata[pcr_pkg::COUNT_W-1:0]);
                        end
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else if (spans_pending.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
                recv_stall <= $urandom_range(0, 9);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && cycles > run_limit) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int pick;
        int lo;
        int width;

        add_span(0, 0);
        add_span(1, 1);
        add_span(2, 2);
        add_span(3, 3);
        add_span(4, 4);
        add_span(9, 9);
        add_span(25, 25);
        add_span(49, 49);
        add_span(2, 3);
        add_span(3, 2);
        add_span(0, 1);
        add_span(-5, 2);
        add_span(-1, -5);
        add_span(-32768, -32768);
        add_span(-32768, 1);
        add_span(-32768, 10);
        add_span(32767, 32767);
        add_span(32761, 32761);
        add_span(32767, 32749);
        add_span(32740, 32767);
        add_span(1, 100);
        add_span(100, 1);
        add_span(1000, -1);
        add_span(-1, -32768);

        for (int k = 0; k < RANDOM_SPANS; k++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                lo    = int'(bound_t'($urandom()));
                width = $urandom_range(0, 30);
                if (lo > 32767 - width) begin
                    lo = 32767 - width;
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_span(lo, lo + width);
                end else begin
                    add_span(lo + width, lo);
                end
            end else if (pick <= 7) begin
                lo = int'($urandom_range(0, 340)) - 40;
                add_span(lo + int'($urandom_range(0, 300)), lo);
            end else if (pick == 8) begin
                add_span(-int'($urandom_range(1, 32768)), $urandom_range(0, 200));
            end else begin
                add_span(int'(bound_t'($urandom() | 32'h8000)),
                         int'(bound_t'($urandom() | 32'h8000)));
            end
        end

        run_limit = 4 * work_total + 20000;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (spans_pending.size() != 0 || s_tvalid || counts_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);

        if (counts_due.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[prime_count_in_range.f]
+incdir+hw/rtl
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_ctrl.sv
hw/rtl/pcr_dpath.sv
hw/rtl/prime_count_in_range.sv
verif/testbench.sv
